// ----- sv/pdg3c_pkg.sv -----
`default_nettype none
package pdg3c_pkg;

  localparam int unsigned QW         = 24;
  localparam int unsigned NDIG       = 4;
  localparam logic [31:0] IDA_LIMIT  = 32'd10000000;
  localparam logic [QW-1:0] RECIP10  = 24'd13421773;
  localparam int unsigned RECIP_SH   = 27;

  localparam logic [31:0] ID_OVR0_A  = 32'd1000017;
  localparam logic [31:0] ID_OVR0_B  = 32'd1000018;
  localparam logic [31:0] ID_OVR0_C  = 32'd1000034;
  localparam logic [31:0] ID_OVR0_D  = 32'd1000052;
  localparam logic [31:0] ID_OVR0_E  = 32'd1000053;
  localparam logic [31:0] ID_OVR0_F  = 32'd1000054;
  localparam logic [31:0] ID_OVR6_A  = 32'd5100061;
  localparam logic [31:0] ID_OVR6_B  = 32'd5100062;
  localparam logic [31:0] ID_HUNDRED = 32'd100;

  localparam int unsigned SLOT_J  = 0;
  localparam int unsigned SLOT_Q3 = 1;
  localparam int unsigned SLOT_Q2 = 2;
  localparam int unsigned SLOT_Q1 = 3;

  typedef struct packed {
    logic                  neg;
    logic                  zero;
    logic                  ovr0;
    logic                  ovr6;
    logic                  eq100;
    logic [NDIG-1:0][3:0]  digits;
  } tok_t;

  function automatic logic signed [3:0] charge_lookup(input logic [6:0] idx);
    logic signed [3:0] c;
    c = 4'sd0;
    case (idx)
      7'd0, 7'd2, 7'd4, 7'd6:     c = -4'sd1;
      7'd1, 7'd3, 7'd5, 7'd7:     c = 4'sd2;
      7'd10, 7'd12, 7'd14, 7'd16: c = -4'sd3;
      7'd23, 7'd33, 7'd36, 7'd52: c = 4'sd3;
      7'd41:                      c = -4'sd1;
      7'd51, 7'd53:               c = 4'sd6;
      default:                    c = 4'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [3:0] quark_charge(input logic [3:0] d);
    logic signed [3:0] c;
    if (d == 4'd0 || d > 4'd9) begin
      c = 4'sd0;
    end else begin
      c = charge_lookup({3'd0, d} - 7'd1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- sv/pdg3c_front.sv -----
`default_nettype none
module pdg3c_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output      logic                       in_ready,
  input  wire logic signed [31:0]         particle_id,
  output      logic                       out_valid,
  input  wire logic                       out_ready,
  output      logic [pdg3c_pkg::QW-1:0]   out_q,
  output      pdg3c_pkg::tok_t            out_tok
);

  logic               valid;
  logic [31:0]        raw;
  logic [31:0]        ida;
  pdg3c_pkg::tok_t    tok_next;

  assign raw = particle_id;
  assign ida = raw[31] ? (32'd0 - raw) : raw;

  always_comb begin
    tok_next        = '0;
    tok_next.neg    = raw[31];
    tok_next.zero   = (ida == 32'd0) || (ida >= pdg3c_pkg::IDA_LIMIT);
    tok_next.ovr0   = (ida == pdg3c_pkg::ID_OVR0_A) || (ida == pdg3c_pkg::ID_OVR0_B) ||
                      (ida == pdg3c_pkg::ID_OVR0_C) || (ida == pdg3c_pkg::ID_OVR0_D) ||
                      (ida == pdg3c_pkg::ID_OVR0_E) || (ida == pdg3c_pkg::ID_OVR0_F);
    tok_next.ovr6   = (ida == pdg3c_pkg::ID_OVR6_A) || (ida == pdg3c_pkg::ID_OVR6_B);
    tok_next.eq100  = (ida == pdg3c_pkg::ID_HUNDRED);
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_q   <= ida[pdg3c_pkg::QW-1:0];
      out_tok <= tok_next;
    end
  end

endmodule
`default_nettype wire

// ----- sv/pdg3c_cell.sv -----
`default_nettype none
module pdg3c_cell #(
  parameter int unsigned SLOT = 0
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output      logic                       in_ready,
  input  wire logic [pdg3c_pkg::QW-1:0]   in_q,
  input  wire pdg3c_pkg::tok_t            in_tok,
  output      logic                       out_valid,
  input  wire logic                       out_ready,
  output      logic [pdg3c_pkg::QW-1:0]   out_q,
  output      pdg3c_pkg::tok_t            out_tok
);

  logic                          valid;
  logic [2*pdg3c_pkg::QW-1:0]    prod;
  logic [pdg3c_pkg::QW-1:0]      quot;
  logic [pdg3c_pkg::QW-1:0]      rem;
  pdg3c_pkg::tok_t               tok_next;

  assign prod = in_q * pdg3c_pkg::RECIP10;
  assign quot = {{(pdg3c_pkg::RECIP_SH - pdg3c_pkg::QW){1'b0}},
                 prod[2*pdg3c_pkg::QW-1:pdg3c_pkg::RECIP_SH]};
  assign rem  = in_q - ((quot << 3) + (quot << 1));

  always_comb begin
    tok_next              = in_tok;
    tok_next.digits[SLOT] = rem[3:0];
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_q   <= quot;
      out_tok <= tok_next;
    end
  end

endmodule
`default_nettype wire

// ----- sv/pdg3c_charge.sv -----
`default_nettype none
module pdg3c_charge (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire pdg3c_pkg::tok_t    in_tok,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic signed [3:0]  triple_charge
);

  logic              valid;
  logic [3:0]        dj, d3, d2, d1;
  logic [6:0]        sid;
  logic signed [4:0] ch;
  logic signed [4:0] ch_signed;
  logic signed [4:0] qc3, qc2, qc1;

  assign dj  = in_tok.digits[pdg3c_pkg::SLOT_J];
  assign d3  = in_tok.digits[pdg3c_pkg::SLOT_Q3];
  assign d2  = in_tok.digits[pdg3c_pkg::SLOT_Q2];
  assign d1  = in_tok.digits[pdg3c_pkg::SLOT_Q1];
  assign sid = ({3'd0, d3} << 3) + ({3'd0, d3} << 1) + {3'd0, dj};
  assign qc3 = 5'(pdg3c_pkg::quark_charge(d3));
  assign qc2 = 5'(pdg3c_pkg::quark_charge(d2));
  assign qc1 = 5'(pdg3c_pkg::quark_charge(d1));

  always_comb begin
    ch = 5'sd0;
    if (in_tok.zero || in_tok.eq100) begin
      ch = 5'sd0;
    end else if (d1 == 4'd0 && d2 == 4'd0) begin
      if (sid != 7'd0) begin
        ch = 5'(pdg3c_pkg::charge_lookup(sid - 7'd1));
        if (in_tok.ovr0) begin
          ch = 5'sd0;
        end
        if (in_tok.ovr6) begin
          ch = 5'sd6;
        end
      end
    end else if (dj == 4'd0) begin
      ch = 5'sd0;
    end else if (d1 == 4'd0) begin
      if (d2 == 4'd3 || d2 == 4'd5) begin
        ch = qc3 - qc2;
      end else begin
        ch = qc2 - qc3;
      end
    end else if (d3 == 4'd0) begin
      ch = qc2 + qc1;
    end else begin
      ch = qc3 + qc2 + qc1;
    end
    ch_signed = in_tok.neg ? -ch : ch;
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      triple_charge <= ch_signed[3:0];
    end
  end

endmodule
`default_nettype wire

// ----- sv/pdg_id_three_charge_core.sv -----
// Three times the electric charge of a signed particle numbering-scheme ID.
// Input channel: in_valid / in_ready with particle_id (32-bit signed).
// Output channel: out_valid / out_ready with triple_charge (4-bit signed,
// -6..6). Each input beat yields exactly one output beat, in order.
// Stages: six register stages (one magnitude/compare stage, four digit
// cells, one charge stage), passed in that order before out_valid rises.
// Throughput: one beat per cycle while out_ready is high; every stage is a
// one-entry register with its own valid, each decimal digit cell holding
// one multiply-by-reciprocal.
// When the receiver stalls, the output holds and the stages behind it fill
// one by one; in_ready drops only once every stage is occupied. Bubbles
// inside the chain are squeezed out while the output waits.
// Reset (rst, synchronous) empties all stages; no result is pending after.
`default_nettype none
module pdg_id_three_charge_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic signed [31:0] particle_id,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic signed [3:0]  triple_charge
);

  localparam int unsigned N = pdg3c_pkg::NDIG;

  logic                       v   [N+1];
  logic                       r   [N+1];
  logic [pdg3c_pkg::QW-1:0]   q   [N+1];
  pdg3c_pkg::tok_t            tok [N+1];

  pdg3c_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .particle_id (particle_id),
    .out_valid   (v[0]),
    .out_ready   (r[0]),
    .out_q       (q[0]),
    .out_tok     (tok[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    pdg3c_cell #(
      .SLOT (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v[i]),
      .in_ready  (r[i]),
      .in_q      (q[i]),
      .in_tok    (tok[i]),
      .out_valid (v[i+1]),
      .out_ready (r[i+1]),
      .out_q     (q[i+1]),
      .out_tok   (tok[i+1])
    );
  end

  pdg3c_charge u_charge (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (v[N]),
    .in_ready      (r[N]),
    .in_tok        (tok[N]),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .triple_charge (triple_charge)
  );

endmodule
`default_nettype wire

// ----- tb/tb_pdg_id_three_charge_core.sv -----
`timescale 1ns / 100ps

module tb_pdg_id_three_charge_core;

  typedef struct {
    logic signed [31:0] id;
    logic signed [3:0]  charge;
  } charge_entry_t;

  class charge_scoreboard;
    charge_entry_t pending[$];
    int            errors;
    int            checked;

    function new();
      errors  = 0;
      checked = 0;
    endfunction

    function int table_charge(int idx);
      case (idx)
        1, 3, 5, 7:     return -1;
        2, 4, 6, 8:     return 2;
        11, 13, 15, 17: return -3;
        24, 34, 37, 53: return 3;
        42:             return -1;
        52, 54:         return 6;
        default:        return 0;
      endcase
    endfunction

    function int digit_charge(int d);
      if (d == 0) return 0;
      return table_charge(d);
    endfunction

    function logic signed [3:0] triple_charge_of_id(logic signed [31:0] id);
      logic [31:0] mag;
      int          units;
      int          tens;
      int          hundreds;
      int          thousands;
      int          idx;
      int          q;
      mag = id[31] ? (32'd0 - id) : id;
      if (mag == 32'd0 || mag >= 32'd10000000) return 4'sd0;
      units     = int'(mag % 10);
      tens      = int'((mag / 10) % 10);
      hundreds  = int'((mag / 100) % 10);
      thousands = int'((mag / 1000) % 10);
      if (hundreds == 0 && thousands == 0) idx = int'(mag % 10000);
      else if (mag <= 32'd102) idx = int'(mag);
      else idx = 0;
      if (idx >= 1 && idx <= 100) begin
        q = table_charge(idx);
        if (mag == 32'd1000017 || mag == 32'd1000018 || mag == 32'd1000034 ||
            mag == 32'd1000052 || mag == 32'd1000053 || mag == 32'd1000054) q = 0;
        if (mag == 32'd5100061 || mag == 32'd5100062) q = 6;
      end else if (units == 0) begin
        return 4'sd0;
      end else if (thousands == 0) begin
        if (hundreds == 3 || hundreds == 5) q = digit_charge(tens) - digit_charge(hundreds);
        else q = digit_charge(hundreds) - digit_charge(tens);
      end else if (tens == 0) begin
        q = digit_charge(hundreds) + digit_charge(thousands);
      end else begin
        q = digit_charge(tens) + digit_charge(hundreds) + digit_charge(thousands);
      end
      if (id[31]) q = -q;
      return q[3:0];
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void note_id(logic signed [31:0] id);
      charge_entry_t e;
      e.id     = id;
      e.charge = triple_charge_of_id(id);
      pending.push_back(e);
    endfunction

    task check_charge(logic signed [3:0] got);
      charge_entry_t e;
      checked++;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected beat, charge %0d", got));
      end else begin
        e = pending.pop_front();
        if (got !== e.charge)
          report_mismatch($sformatf("id %0d: charge %0d, want %0d", e.id, got, e.charge));
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] particle_id = 32'sd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [3:0]  triple_charge;

  logic             started = 1'b0;
  logic             no_idle = 1'b0;
  logic             stall_done = 1'b0;
  charge_scoreboard board;

  pdg_id_three_charge_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .particle_id  (particle_id),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .triple_charge(triple_charge)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic signed [31:0] directed_ids [0:24] = '{
    32'sd0, 32'sd1, -32'sd1, 32'sh7fffffff, 32'sh80000000,
    32'sd9999999, 32'sd10000000, -32'sd9999999, 32'sd100, 32'sd102,
    32'sd103, 32'sd1000017, -32'sd1000018, 32'sd1000034, 32'sd1000052,
    -32'sd1000053, 32'sd1000054, 32'sd5100061, -32'sd5100062, 32'sd211,
    -32'sd321, 32'sd2101, 32'sd2212, 32'sd2110, 32'sd203
  };

  function int draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 13);
  endfunction

  function logic signed [31:0] random_id();
    logic [31:0] mag;
    int          pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1: return $urandom;
      2, 3, 4, 5: mag = $urandom_range(0, 999) * 10000 + $urandom_range(0, 9) * 1000 +
                        $urandom_range(0, 9) * 100 + $urandom_range(0, 9) * 10 +
                        $urandom_range(0, 9);
      6: mag = $urandom_range(0, 120);
      7: begin
        case ($urandom_range(0, 7))
          0: mag = 32'd1000017;
          1: mag = 32'd1000018;
          2: mag = 32'd1000034;
          3: mag = 32'd1000052;
          4: mag = 32'd1000053;
          5: mag = 32'd1000054;
          6: mag = 32'd5100061;
          default: mag = 32'd5100062;
        endcase
        mag = mag + $urandom_range(0, 2) - 1;
      end
      8: mag = $urandom_range(0, 999) * 10000 + $urandom_range(0, 100);
      default: mag = $urandom_range(0, 9999999);
    endcase
    if ($urandom_range(0, 1)) mag = 32'd0 - mag;
    return mag;
  endfunction

  task send_id(input logic signed [31:0] v);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    particle_id <= v;
    do @(posedge clk); while (!in_ready);
    board.note_id(v);
  endtask

  initial begin
    int gap;
    wait (started);
    @(posedge clk);
    forever begin
      gap = draw_gap();
      if (!stall_done && board.checked >= 120) begin
        stall_done = 1'b1;
        gap = 200;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_charge(triple_charge);
    end
  end

  initial begin
    board = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    started = 1'b1;
    foreach (directed_ids[i]) send_id(directed_ids[i]);
    for (int n = 0; n < 550; n++) begin
      no_idle = (n >= 250 && n < 350);
      send_id(random_id());
    end
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("pdg_id_three_charge_core verification clean");
    end else begin
      $display("pdg_id_three_charge_core verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("pdg_id_three_charge_core verification failed");
    $finish;
  end

endmodule
